// ===== src/lcdn_pkg.sv =====
// Shared types and constants for the 4-bit character LCD interface.
// Used by the front decoder, the request queue and the sequencer back end.
// No dependencies.
package lcdn_pkg;

    localparam int unsigned COUNTER_WIDTH_DEF = 8;
    localparam int unsigned CFG_WIDTH         = 8;
    localparam int unsigned CFG_IDX_WIDTH     = 2;
    localparam int unsigned Q_DEPTH           = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_ENABLE_TICKS   = 2'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_BYTE_GAP_TICKS = 2'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_POWER_UP_TICKS = 2'd2;

    localparam logic [7:0] ENABLE_TICKS_RST   = 8'd1;
    localparam logic [7:0] BYTE_GAP_TICKS_RST = 8'd2;
    localparam logic [7:0] POWER_UP_TICKS_RST = 8'd40;

    // Request function codes on the input stream
    localparam logic [2:0] FUNC_TICK   = 3'd0;
    localparam logic [2:0] FUNC_CMD    = 3'd1;
    localparam logic [2:0] FUNC_DATA   = 3'd2;
    localparam logic [2:0] FUNC_CURSOR = 3'd3;
    localparam logic [2:0] FUNC_INIT   = 3'd4;

    // Display constants
    localparam logic [7:0] ROW0_BASE     = 8'h80;
    localparam logic [7:0] ROW1_BASE     = 8'hC0;
    localparam logic [7:0] CMD_FUNC_SET  = 8'h28;
    localparam logic [7:0] CMD_DISP_ON   = 8'h0C;
    localparam logic [7:0] CMD_CLEAR     = 8'h01;
    localparam logic [7:0] CMD_ENTRY     = 8'h06;
    localparam logic [3:0] NIB_WAKE      = 4'h3;
    localparam logic [3:0] NIB_FOUR_BIT  = 4'h2;
    localparam logic [7:0] WAIT_SHORT    = 8'd5;
    localparam logic [7:0] WAIT_LONG     = 8'd150;
    localparam logic [7:0] WAIT_CLEAR    = 8'd2;

    typedef enum logic [1:0] {
        K_NOP,
        K_TICK,
        K_BYTE,
        K_INIT
    } t_kind;

    // Classified request as it travels through the queue
    typedef struct packed {
        t_kind      kind;
        logic       rs;
        logic [7:0] byte_value;
    } t_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

// ===== src/lcdn_front.sv =====
// Front end of the LCD interface: decodes the request function and builds
// the byte to send (cursor address included). Depends on lcdn_pkg.
module lcdn_front
    import lcdn_pkg::*;
(
    input  logic [2:0] i_func,
    input  logic [7:0] i_byte_value,
    input  logic       i_row,
    input  logic [5:0] i_col,
    output t_item      o_item
);

    logic [7:0] w_cursor;

    assign w_cursor = (i_row ? ROW1_BASE : ROW0_BASE) + {2'b00, i_col};

    always_comb begin
        o_item.kind       = K_NOP;
        o_item.rs         = 1'b0;
        o_item.byte_value = i_byte_value;
        case (i_func)
            FUNC_TICK: begin
                o_item.kind = K_TICK;
            end
            FUNC_CMD: begin
                o_item.kind = K_BYTE;
            end
            FUNC_DATA: begin
                o_item.kind = K_BYTE;
                o_item.rs   = 1'b1;
            end
            FUNC_CURSOR: begin
                o_item.kind       = K_BYTE;
                o_item.byte_value = w_cursor;
            end
            FUNC_INIT: begin
                o_item.kind = K_INIT;
            end
            default: begin
                o_item.kind = K_NOP;
            end
        endcase
    end

endmodule

// ===== src/lcdn_queue.sv =====
// Short request queue between the front decoder and the sequencer.
// Depth from lcdn_pkg::Q_DEPTH. Depends on lcdn_pkg.
module lcdn_queue
    import lcdn_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_item     i_push_item,
    input  logic      i_pop,
    output t_item     o_pop_item,
    output t_q_status o_status
);

    localparam int unsigned PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int unsigned CW = $clog2(Q_DEPTH + 1);

    t_item           r_mem [Q_DEPTH];
    logic [PW-1:0]   r_wr_ptr;
    logic [PW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_count;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PW'(Q_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_status.full  = (r_count == CW'(Q_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign o_pop_item     = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== src/lcdn_back.sv =====
// Sequencer back end: runs byte, nibble and init timing from tick items and
// registers one pin/status result per item. Depends on lcdn_pkg.
module lcdn_back
    import lcdn_pkg::*;
#(
    parameter int unsigned COUNTER_WIDTH = COUNTER_WIDTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_WIDTH-1:0] i_cfg_idx,
    input  logic [CFG_WIDTH-1:0]     i_cfg_data,
    input  t_q_status                i_q_status,
    input  t_item                    i_item,
    output logic                     o_pop,
    output logic                     o_tvalid,
    input  logic                     i_tready,
    output logic [7:0]               o_tdata
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_BYTE_HI,
        PH_BYTE_LO,
        PH_GAP,
        PH_SOLO_HI,
        PH_SOLO_LO
    } t_phase;

    typedef enum logic [3:0] {
        INIT_OFF,
        INIT_POWER,
        INIT_NIB1,
        INIT_WAIT1,
        INIT_NIB2,
        INIT_WAIT2,
        INIT_NIB3,
        INIT_NIB4,
        INIT_FUNC,
        INIT_DISP,
        INIT_CLR,
        INIT_CLRW,
        INIT_MODE
    } t_init;

    logic [7:0]               r_enable_ticks;
    logic [7:0]               r_byte_gap_ticks;
    logic [7:0]               r_power_up_ticks;

    t_phase                   r_phase,   n_phase;
    t_init                    r_init,    n_init;
    logic [COUNTER_WIDTH-1:0] r_wait,    n_wait;
    logic [7:0]               r_pending, n_pending;
    logic                     r_half,    n_half;
    logic                     r_rs,      n_rs;
    logic                     r_en,      n_en;
    logic [3:0]               r_nib,     n_nib;
    logic                     n_rej;
    logic                     n_adv;

    logic                     r_out_valid;
    logic [7:0]               r_out;

    assign o_pop    = !i_q_status.empty && (!r_out_valid || i_tready);
    assign o_tvalid = r_out_valid;
    assign o_tdata  = r_out;

    // Configuration must only be written while idle; the block itself does not enforce this
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable_ticks   <= ENABLE_TICKS_RST;
            r_byte_gap_ticks <= BYTE_GAP_TICKS_RST;
            r_power_up_ticks <= POWER_UP_TICKS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ENABLE_TICKS:   r_enable_ticks   <= i_cfg_data;
                CFG_BYTE_GAP_TICKS: r_byte_gap_ticks <= i_cfg_data;
                CFG_POWER_UP_TICKS: r_power_up_ticks <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_phase   = r_phase;
        n_init    = r_init;
        n_wait    = r_wait;
        n_pending = r_pending;
        n_half    = r_half;
        n_rs      = r_rs;
        n_en      = r_en;
        n_nib     = r_nib;
        n_rej     = 1'b0;
        n_adv     = 1'b0;

        case (i_item.kind)
            K_TICK: begin
                if (r_phase != PH_IDLE) begin
                    if (r_wait > COUNTER_WIDTH'(1)) begin
                        n_wait = r_wait - 1'b1;
                    end else begin
                        n_wait = '0;
                        case (r_phase)
                            PH_BYTE_HI: begin
                                n_en    = 1'b0;
                                n_wait  = COUNTER_WIDTH'(r_enable_ticks);
                                n_phase = PH_BYTE_LO;
                            end
                            PH_SOLO_HI: begin
                                n_en    = 1'b0;
                                n_wait  = COUNTER_WIDTH'(r_enable_ticks);
                                n_phase = PH_SOLO_LO;
                            end
                            PH_BYTE_LO: begin
                                if (!r_half) begin
                                    // advance to the low nibble
                                    n_half  = 1'b1;
                                    n_nib   = r_pending[3:0];
                                    n_en    = 1'b1;
                                    n_wait  = COUNTER_WIDTH'(r_enable_ticks);
                                    n_phase = PH_BYTE_HI;
                                end else begin
                                    n_wait  = COUNTER_WIDTH'(r_byte_gap_ticks);
                                    n_phase = PH_GAP;
                                end
                            end
                            PH_SOLO_LO, PH_GAP: begin
                                if (r_init != INIT_OFF) begin
                                    n_adv = 1'b1;
                                end else begin
                                    n_phase = PH_IDLE;
                                end
                            end
                            default: begin
                                n_phase = PH_IDLE;
                                n_init  = INIT_OFF;
                            end
                        endcase
                    end
                end
            end
            K_BYTE: begin
                if (r_phase != PH_IDLE) begin
                    n_rej = 1'b1;
                end else begin
                    n_pending = i_item.byte_value;
                    n_rs      = i_item.rs;
                    n_half    = 1'b0;
                    n_nib     = i_item.byte_value[7:4];
                    n_en      = 1'b1;
                    n_wait    = COUNTER_WIDTH'(r_enable_ticks);
                    n_phase   = PH_BYTE_HI;
                end
            end
            K_INIT: begin
                if (r_phase != PH_IDLE) begin
                    n_rej = 1'b1;
                end else begin
                    n_rs    = 1'b0;
                    n_en    = 1'b0;
                    n_init  = INIT_POWER;
                    n_wait  = COUNTER_WIDTH'(r_power_up_ticks);
                    n_phase = PH_GAP;
                end
            end
            default: ;
        endcase

        // Step the power-up sequence once the current step has finished
        if (n_adv) begin
            n_rs = 1'b0;
            case (r_init)
                INIT_POWER, INIT_WAIT1, INIT_WAIT2, INIT_NIB3: begin
                    n_nib   = (r_init == INIT_NIB3) ? NIB_FOUR_BIT : NIB_WAKE;
                    n_en    = 1'b1;
                    n_wait  = COUNTER_WIDTH'(r_enable_ticks);
                    n_phase = PH_SOLO_HI;
                    n_init  = t_init'(r_init + 1'b1);
                end
                INIT_NIB1, INIT_NIB2, INIT_CLR: begin
                    n_wait  = COUNTER_WIDTH'((r_init == INIT_NIB1) ? WAIT_SHORT :
                              (r_init == INIT_NIB2) ? WAIT_LONG : WAIT_CLEAR);
                    n_phase = PH_GAP;
                    n_init  = t_init'(r_init + 1'b1);
                end
                INIT_NIB4, INIT_FUNC, INIT_DISP, INIT_CLRW: begin
                    case (r_init)
                        INIT_NIB4: n_pending = CMD_FUNC_SET;
                        INIT_FUNC: n_pending = CMD_DISP_ON;
                        INIT_DISP: n_pending = CMD_CLEAR;
                        default:   n_pending = CMD_ENTRY;
                    endcase
                    n_half  = 1'b0;
                    n_nib   = n_pending[7:4];
                    n_en    = 1'b1;
                    n_wait  = COUNTER_WIDTH'(r_enable_ticks);
                    n_phase = PH_BYTE_HI;
                    n_init  = t_init'(r_init + 1'b1);
                end
                default: begin
                    n_init  = INIT_OFF;
                    n_phase = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_init      <= INIT_OFF;
            r_wait      <= '0;
            r_pending   <= '0;
            r_half      <= 1'b0;
            r_rs        <= 1'b0;
            r_en        <= 1'b0;
            r_nib       <= '0;
            r_out_valid <= 1'b0;
            r_out       <= '0;
        end else if (o_pop) begin
            r_phase     <= n_phase;
            r_init      <= n_init;
            r_wait      <= n_wait;
            r_pending   <= n_pending;
            r_half      <= n_half;
            r_rs        <= n_rs;
            r_en        <= n_en;
            r_nib       <= n_nib;
            r_out_valid <= 1'b1;
            // {rejected, busy, nibble, enable, rs}
            r_out       <= {n_rej, (n_phase != PH_IDLE), n_nib, n_en, n_rs};
        end else if (i_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    a_rej_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out[7]) |-> r_out[6])
        else $error("rejected result without busy");

    a_idle_no_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_IDLE) |-> (r_init == INIT_OFF))
        else $error("idle with init sequence pending");

    a_en_high_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_en |-> (r_phase == PH_BYTE_HI || r_phase == PH_SOLO_HI))
        else $error("enable high outside a high phase");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_q_status.empty |-> !o_pop)
        else $error("pop from empty queue");

endmodule

// ===== src/char_lcd_nibble_interface_core.sv =====
// 4-bit character LCD interface: one result transaction per input transaction.
// The sequencer takes one item (tick or request) per cycle while the result output is
// not stalled; a result passes through a two-entry request queue and the sequencer's
// output register, where output back-pressure can hold it.
// Depends on lcdn_pkg, lcdn_front, lcdn_queue and lcdn_back.
module char_lcd_nibble_interface_core
    import lcdn_pkg::*;
#(
    parameter int unsigned COUNTER_WIDTH = COUNTER_WIDTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_WIDTH-1:0] i_cfg_idx,
    input  logic [CFG_WIDTH-1:0]     i_cfg_data,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    // [7:0] byte_value, [8] row, [14:9] col, [15] zero
    input  logic [15:0]              s_axis_tdata,
    // [2:0] func
    input  logic [2:0]               s_axis_tuser,
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    // [0] reg_select, [1] enable_pin, [5:2] data_nibble, [6] busy_res, [7] rejected
    output logic [7:0]               m_axis_tdata
);

    t_item     w_in_item;
    t_item     w_q_item;
    t_q_status w_q_status;
    logic      w_push;
    logic      w_pop;

    assign s_axis_tready = !w_q_status.full;
    assign w_push        = s_axis_tvalid && s_axis_tready;

    lcdn_front u_front (
        .i_func       (s_axis_tuser),
        .i_byte_value (s_axis_tdata[7:0]),
        .i_row        (s_axis_tdata[8]),
        .i_col        (s_axis_tdata[14:9]),
        .o_item       (w_in_item)
    );

    lcdn_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_item (w_in_item),
        .i_pop       (w_pop),
        .o_pop_item  (w_q_item),
        .o_status    (w_q_status)
    );

    lcdn_back #(
        .COUNTER_WIDTH (COUNTER_WIDTH)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_q_status (w_q_status),
        .i_item     (w_q_item),
        .o_pop      (w_pop),
        .o_tvalid   (m_axis_tvalid),
        .i_tready   (m_axis_tready),
        .o_tdata    (m_axis_tdata)
    );

endmodule

// ===== tb/testbench.sv =====
// Self-checking bench for char_lcd_nibble_interface_core: directed table, then random phases.
// Holds its own model of the nibble sequencer and compares every result transaction with it,
// or with the table's value for typed directed rows. Depends on lcdn_pkg and the core RTL.
module testbench;
    import lcdn_pkg::*;

    typedef enum logic [2:0] {
        SQ_IDLE,
        SQ_BYTE_HI,
        SQ_BYTE_LO,
        SQ_GAP,
        SQ_SOLO_HI,
        SQ_SOLO_LO
    } t_seq_phase;

    // Same bit order as m_axis_tdata
    typedef struct packed {
        logic       rejected;
        logic       busy;
        logic [3:0] nibble;
        logic       enable;
        logic       rs;
    } t_lcd_pins;

    typedef struct packed {
        logic [2:0] func;
        logic [7:0] bval;
        logic       row;
        logic [5:0] col;
        logic [8:0] reps;
        logic       typed;
        t_lcd_pins  want;
    } t_dir_row;

    localparam int N_DIR = 19;

    // want: {rejected, busy, nibble[3:0], enable, rs}; default settings 1/2/40
    localparam t_dir_row DIR_TAB [N_DIR] = '{
        '{FUNC_TICK,   8'h00, 1'b0, 6'h00, 9'd1,   1'b1, 8'h00},
        '{3'd5,        8'h00, 1'b0, 6'h00, 9'd1,   1'b1, 8'h00},
        '{3'd7,        8'hFF, 1'b1, 6'h3F, 9'd1,   1'b1, 8'h00},
        '{FUNC_CMD,    8'hFF, 1'b0, 6'h00, 9'd1,   1'b1, 8'h7E},
        '{FUNC_DATA,   8'h00, 1'b1, 6'h3F, 9'd1,   1'b1, 8'hFE},
        '{FUNC_TICK,   8'h00, 1'b0, 6'h00, 9'd6,   1'b0, 8'h00},
        '{FUNC_DATA,   8'hA5, 1'b0, 6'h00, 9'd1,   1'b1, 8'h6B},
        '{FUNC_INIT,   8'h00, 1'b0, 6'h00, 9'd1,   1'b1, 8'hEB},
        '{FUNC_TICK,   8'h00, 1'b0, 6'h00, 9'd6,   1'b0, 8'h00},
        '{FUNC_CURSOR, 8'h00, 1'b0, 6'h3F, 9'd1,   1'b1, 8'h6E},
        '{FUNC_TICK,   8'h00, 1'b0, 6'h00, 9'd6,   1'b0, 8'h00},
        '{FUNC_CURSOR, 8'h00, 1'b1, 6'h00, 9'd1,   1'b1, 8'h72},
        '{FUNC_TICK,   8'h00, 1'b0, 6'h00, 9'd6,   1'b0, 8'h00},
        '{FUNC_CMD,    8'h00, 1'b0, 6'h00, 9'd1,   1'b1, 8'h42},
        '{FUNC_TICK,   8'h00, 1'b0, 6'h00, 9'd6,   1'b0, 8'h00},
        '{FUNC_INIT,   8'h00, 1'b0, 6'h00, 9'd1,   1'b1, 8'h40},
        '{FUNC_CURSOR, 8'h00, 1'b1, 6'h15, 9'd1,   1'b1, 8'hC0},
        '{FUNC_TICK,   8'h00, 1'b0, 6'h00, 9'd260, 1'b0, 8'h00},
        '{3'd6,        8'h5A, 1'b1, 6'h2A, 9'd1,   1'b0, 8'h00}
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [CFG_IDX_WIDTH-1:0] i_cfg_idx;
    logic [CFG_WIDTH-1:0]     i_cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;
    logic [2:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;

    bit          steady = 1'b0;
    int          mismatch_count = 0;
    int          result_idx = 0;
    t_lcd_pins   expected_pins[$];

    // Sequencer model state and its copy of the settings
    t_seq_phase  sq_phase;
    logic [3:0]  sq_init_step;
    logic [7:0]  sq_wait;
    logic [7:0]  sq_byte;
    logic        sq_half;
    logic        sq_rs;
    logic        sq_en;
    logic [3:0]  sq_nib;
    logic [7:0]  reg_enable;
    logic [7:0]  reg_gap;
    logic [7:0]  reg_power;

    char_lcd_nibble_interface_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    function automatic void nib_begin(input logic [3:0] nib, input t_seq_phase ph);
        sq_nib = nib;
        sq_en = 1'b1;
        sq_wait = reg_enable;
        sq_phase = ph;
    endfunction

    function automatic void byte_begin(input logic [7:0] b, input logic rs);
        sq_byte = b;
        sq_rs = rs;
        sq_half = 1'b0;
        nib_begin(b[7:4], SQ_BYTE_HI);
    endfunction

    function automatic void gap_begin(input logic [7:0] n);
        sq_wait = n;
        sq_phase = SQ_GAP;
    endfunction

    function automatic void lcd_tick();
        if (sq_phase == SQ_IDLE)
            return;
        if (sq_wait > 8'd1) begin
            sq_wait = sq_wait - 8'd1;
            return;
        end
        sq_wait = 8'd0;
        case (sq_phase)
            SQ_BYTE_HI, SQ_SOLO_HI: begin
                sq_en = 1'b0;
                sq_wait = reg_enable;
                sq_phase = (sq_phase == SQ_BYTE_HI) ? SQ_BYTE_LO : SQ_SOLO_LO;
            end
            SQ_BYTE_LO: begin
                if (!sq_half) begin
                    sq_half = 1'b1;
                    nib_begin(sq_byte[3:0], SQ_BYTE_HI);
                end else begin
                    gap_begin(reg_gap);
                end
            end
            SQ_SOLO_LO, SQ_GAP: begin
                if (sq_init_step == 4'd0) begin
                    sq_phase = SQ_IDLE;
                end else begin
                    // step the power-up script
                    sq_rs = 1'b0;
                    case (sq_init_step)
                        4'd1:  begin sq_init_step = 4'd2;  nib_begin(NIB_WAKE, SQ_SOLO_HI); end
                        4'd2:  begin sq_init_step = 4'd3;  gap_begin(WAIT_SHORT); end
                        4'd3:  begin sq_init_step = 4'd4;  nib_begin(NIB_WAKE, SQ_SOLO_HI); end
                        4'd4:  begin sq_init_step = 4'd5;  gap_begin(WAIT_LONG); end
                        4'd5:  begin sq_init_step = 4'd6;  nib_begin(NIB_WAKE, SQ_SOLO_HI); end
                        4'd6:  begin
                            sq_init_step = 4'd7;
                            nib_begin(NIB_FOUR_BIT, SQ_SOLO_HI);
                        end
                        4'd7:  begin sq_init_step = 4'd8;  byte_begin(CMD_FUNC_SET, 1'b0); end
                        4'd8:  begin sq_init_step = 4'd9;  byte_begin(CMD_DISP_ON, 1'b0); end
                        4'd9:  begin sq_init_step = 4'd10; byte_begin(CMD_CLEAR, 1'b0); end
                        4'd10: begin sq_init_step = 4'd11; gap_begin(WAIT_CLEAR); end
                        4'd11: begin sq_init_step = 4'd12; byte_begin(CMD_ENTRY, 1'b0); end
                        default: begin
                            sq_init_step = 4'd0;
                            sq_phase = SQ_IDLE;
                        end
                    endcase
                end
            end
            default: begin
                sq_phase = SQ_IDLE;
                sq_init_step = 4'd0;
            end
        endcase
    endfunction

    function automatic t_lcd_pins lcd_predict(input logic [2:0] f, input logic [7:0] b,
                                              input logic r, input logic [5:0] c);
        t_lcd_pins pins;
        pins = '0;
        if (f == FUNC_TICK) begin
            lcd_tick();
        end else if (f <= FUNC_INIT) begin
            if (sq_phase != SQ_IDLE) begin
                pins.rejected = 1'b1;
            end else begin
                case (f)
                    FUNC_CMD:    byte_begin(b, 1'b0);
                    FUNC_DATA:   byte_begin(b, 1'b1);
                    FUNC_CURSOR: byte_begin((r ? ROW1_BASE : ROW0_BASE) + {2'b00, c}, 1'b0);
                    default: begin
                        sq_rs = 1'b0;
                        sq_en = 1'b0;
                        sq_init_step = 4'd1;
                        gap_begin(reg_power);
                    end
                endcase
            end
        end
        pins.rs = sq_rs;
        pins.enable = sq_en;
        pins.nibble = sq_nib;
        pins.busy = (sq_phase != SQ_IDLE);
        return pins;
    endfunction

    task automatic report_mismatch(input string what, input int got_v, input int want_v);
        if (mismatch_count < 100)
            $display("mismatch at result %0d: %s got 0x%0h expected 0x%0h",
                     result_idx, what, got_v, want_v);
        mismatch_count++;
    endtask

    // Checker: compare each result transaction with the oldest expectation
    always @(posedge i_clk) begin : result_check
        t_lcd_pins got;
        t_lcd_pins want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata;
            if (expected_pins.size() == 0) begin
                report_mismatch("unexpected result", got, 0);
            end else begin
                want = expected_pins.pop_front();
                if (got.rs != want.rs)
                    report_mismatch("reg_select", got.rs, want.rs);
                if (got.enable != want.enable)
                    report_mismatch("enable_pin", got.enable, want.enable);
                if (got.nibble != want.nibble)
                    report_mismatch("data_nibble", got.nibble, want.nibble);
                if (got.busy != want.busy)
                    report_mismatch("busy", got.busy, want.busy);
                if (got.rejected != want.rejected)
                    report_mismatch("rejected", got.rejected, want.rejected);
            end
            result_idx++;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= steady || ($urandom_range(0, 99) >= 20);
    end

    task automatic send_item(input logic [2:0] f, input logic [7:0] b, input logic r,
                             input logic [5:0] c, input logic typed, input t_lcd_pins want);
        t_lcd_pins pins;
        while (!steady && $urandom_range(0, 99) < 20) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= f;
        s_axis_tdata <= {1'b0, c, r, b};
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        pins = lcd_predict(f, b, r, c);
        expected_pins.push_back(typed ? want : pins);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (expected_pins.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic load_settings(input logic [7:0] en_t, input logic [7:0] gap_t,
                                 input logic [7:0] pwr_t);
        wait_drained();
        i_cfg_we <= 1'b1;
        i_cfg_idx <= CFG_ENABLE_TICKS;
        i_cfg_data <= en_t;
        @(posedge i_clk);
        reg_enable = en_t;
        i_cfg_idx <= CFG_BYTE_GAP_TICKS;
        i_cfg_data <= gap_t;
        @(posedge i_clk);
        reg_gap = gap_t;
        i_cfg_idx <= CFG_POWER_UP_TICKS;
        i_cfg_data <= pwr_t;
        @(posedge i_clk);
        reg_power = pwr_t;
        i_cfg_we <= 1'b0;
    endtask

    task automatic run_random(input int items, input int tick_pct, input bit no_idle);
        int roll;
        logic [2:0] f;
        steady <= no_idle;
        for (int n = 0; n < items; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < tick_pct) begin
                f = FUNC_TICK;
            end else begin
                roll = $urandom_range(0, 19);
                if (roll < 5)       f = FUNC_CMD;
                else if (roll < 10) f = FUNC_DATA;
                else if (roll < 15) f = FUNC_CURSOR;
                else if (roll < 17) f = FUNC_INIT;
                else                f = 3'($urandom_range(5, 7));
            end
            send_item(f, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                      6'($urandom_range(0, 63)), 1'b0, '0);
            // hold off now and then until the pipeline is empty
            if ($urandom_range(0, 79) == 0)
                wait_drained();
        end
        steady <= 1'b0;
    endtask

    initial begin
        sq_phase = SQ_IDLE;
        sq_init_step = 4'd0;
        sq_wait = 8'd0;
        sq_byte = 8'd0;
        sq_half = 1'b0;
        sq_rs = 1'b0;
        sq_en = 1'b0;
        sq_nib = 4'd0;
        reg_enable = ENABLE_TICKS_RST;
        reg_gap = BYTE_GAP_TICKS_RST;
        reg_power = POWER_UP_TICKS_RST;

        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= CFG_ENABLE_TICKS;
        i_cfg_data <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= '0;
        s_axis_tuser <= FUNC_TICK;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < N_DIR; i++)
            for (int k = 0; k < DIR_TAB[i].reps; k++)
                send_item(DIR_TAB[i].func, DIR_TAB[i].bval, DIR_TAB[i].row,
                          DIR_TAB[i].col, DIR_TAB[i].typed, DIR_TAB[i].want);

        load_settings(8'd1, 8'd1, 8'd1);
        run_random(100, 75, 1'b1);
        // zero counts behave as one tick
        load_settings(8'd0, 8'd0, 8'd0);
        run_random(100, 70, 1'b0);
        load_settings(8'd3, 8'd2, 8'd10);
        run_random(100, 80, 1'b0);
        load_settings(8'd255, 8'd255, 8'd255);
        run_random(200, 98, 1'b0);
        load_settings(8'd4, 8'd1, 8'd255);
        run_random(100, 85, 1'b0);
        load_settings(8'd2, 8'd5, 8'd3);
        run_random(100, 75, 1'b0);

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        #2000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== char_lcd_nibble_interface_core.f =====
src/lcdn_pkg.sv
src/lcdn_front.sv
src/lcdn_queue.sv
src/lcdn_back.sv
src/char_lcd_nibble_interface_core.sv
tb/testbench.sv
